[rtl/coverage_alpha_compositor_defines.svh]
// Assertion macros for the checker file.
`ifndef COVERAGE_ALPHA_COMPOSITOR_DEFINES_SVH
`define COVERAGE_ALPHA_COMPOSITOR_DEFINES_SVH

// Check a property on the rising clock edge, quiet while reset is held.
`define CAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a signal holds while a beat is stalled.
`define CAC_ASSERT_HOLD(lbl, stall, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (stall) |=> $stable(sig)) else $error(msg);

`endif

[rtl/cac_pkg.sv]
`default_nettype none
package cac_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned CanvasW = 13;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned RemW    = 25;
  localparam int unsigned DivW    = 17;
  localparam int unsigned QSteps  = 8;
  localparam int unsigned Lanes   = 4;
  localparam int unsigned AlphaLane = 3;

  localparam logic [1:0] ModeReplace    = 2'd0;
  localparam logic [1:0] ModeOverlay    = 2'd1;
  localparam logic [1:0] ModeErase      = 2'd2;
  localparam logic [1:0] ModeComplement = 2'd3;

  localparam logic [7:0] RegCanvasWidth  = 8'd0;
  localparam logic [7:0] RegCanvasHeight = 8'd1;

  localparam logic [CanvasW-1:0] WidthReset  = 13'd800;
  localparam logic [CanvasW-1:0] HeightReset = 13'd480;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [ChanW-1:0]  src_red;
    logic [ChanW-1:0]  src_green;
    logic [ChanW-1:0]  src_blue;
    logic [1:0]        write_mode;
    logic [ChanW-1:0]  coverage;
    logic [ChanW-1:0]  dst_red;
    logic [ChanW-1:0]  dst_green;
    logic [ChanW-1:0]  dst_blue;
    logic [ChanW-1:0]  dst_alpha;
  } pix_t;

  // Carried alongside the divider lanes.
  typedef struct packed {
    logic             off;
    logic             erase;
    logic [ChanW-1:0] dst_red;
    logic [ChanW-1:0] dst_green;
    logic [ChanW-1:0] dst_blue;
    logic [ChanW-1:0] dst_alpha;
  } side_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [DivW-1:0]  div;
    logic [ChanW-1:0] quo;
  } lane_t;

  typedef lane_t [Lanes-1:0] lanes_t;

endpackage
`default_nettype wire

[rtl/cac_if.sv]
`default_nettype none
interface cac_pix_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [7:0]  src_red;
  logic [7:0]  src_green;
  logic [7:0]  src_blue;
  logic [1:0]  write_mode;
  logic [7:0]  coverage;
  logic [7:0]  dst_red;
  logic [7:0]  dst_green;
  logic [7:0]  dst_blue;
  logic [7:0]  dst_alpha;
  modport source (output valid, pixel_x, pixel_y, src_red, src_green, src_blue, write_mode,
                  coverage, dst_red, dst_green, dst_blue, dst_alpha, input ready);
  modport sink (input valid, pixel_x, pixel_y, src_red, src_green, src_blue, write_mode,
                coverage, dst_red, dst_green, dst_blue, dst_alpha, output ready);
endinterface

interface cac_pix_out_if;
  logic       valid;
  logic       ready;
  logic       write_enable;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  modport source (output valid, write_enable, out_red, out_green, out_blue, out_alpha,
                  input ready);
  modport sink (input valid, write_enable, out_red, out_green, out_blue, out_alpha,
                output ready);
endinterface

interface cac_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/cac_front.sv]
`default_nettype none
module cac_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire cac_pkg::pix_t                 pix_i,
  input  wire logic [cac_pkg::CanvasW-1:0]   width_i,
  input  wire logic [cac_pkg::CanvasW-1:0]   height_i,
  output logic                               valid_o,
  output cac_pkg::lanes_t                    lanes_o,
  output cac_pkg::side_t                     side_o
);

  // Stage one: products of 8-bit values and the skip decision.
  logic               v1_q;
  cac_pkg::side_t     side1_q, side1_d;
  logic [15:0]        a_q [3];
  logic [15:0]        b_q [3];
  logic [15:0]        cov255_q;
  logic [15:0]        dainv_q;
  logic [7:0]         inv_q;
  logic [7:0]         src [3];
  logic [7:0]         dst [3];
  logic [7:0]         inv;

  always_comb begin
    dst[0] = pix_i.dst_red;
    dst[1] = pix_i.dst_green;
    dst[2] = pix_i.dst_blue;
    if (pix_i.write_mode == cac_pkg::ModeComplement) begin
      src[0] = ~pix_i.dst_red;
      src[1] = ~pix_i.dst_green;
      src[2] = ~pix_i.dst_blue;
    end else begin
      src[0] = pix_i.src_red;
      src[1] = pix_i.src_green;
      src[2] = pix_i.src_blue;
    end
    inv = ~pix_i.coverage;
    side1_d.off = pix_i.pixel_x[15] || pix_i.pixel_y[15] ||
                  (pix_i.pixel_x >= {3'b000, width_i}) ||
                  (pix_i.pixel_y >= {3'b000, height_i}) ||
                  (pix_i.coverage == 8'd0);
    side1_d.erase     = (pix_i.write_mode == cac_pkg::ModeErase);
    side1_d.dst_red   = pix_i.dst_red;
    side1_d.dst_green = pix_i.dst_green;
    side1_d.dst_blue  = pix_i.dst_blue;
    side1_d.dst_alpha = pix_i.dst_alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q  <= side1_d;
      for (int k = 0; k < 3; k++) begin
        a_q[k] <= src[k] * pix_i.coverage;
        b_q[k] <= dst[k] * pix_i.dst_alpha;
      end
      cov255_q <= {pix_i.coverage, 8'd0} - {8'd0, pix_i.coverage};
      dainv_q  <= pix_i.dst_alpha * inv;
      inv_q    <= inv;
    end
  end

  // Stage two: numerators and denominator, set up as divider lanes.
  logic [15:0]     den;
  logic [24:0]     num [3];
  cac_pkg::lanes_t lanes_d;

  always_comb begin
    den = cov255_q + dainv_q;
    for (int k = 0; k < 3; k++) begin
      num[k] = ({1'b0, a_q[k], 8'd0} - {9'd0, a_q[k]}) +
               {1'b0, (24'(b_q[k]) * 24'(inv_q))};
      lanes_d[k].rem = {num[k][23:0], 1'b0} + {9'd0, den};
      lanes_d[k].div = {den, 1'b0};
      lanes_d[k].quo = '0;
    end
    if (side1_q.erase) begin
      lanes_d[cac_pkg::AlphaLane].rem = {9'd0, dainv_q};
      lanes_d[cac_pkg::AlphaLane].div = 17'd255;
    end else begin
      lanes_d[cac_pkg::AlphaLane].rem = {8'd0, den, 1'b0} + 25'd255;
      lanes_d[cac_pkg::AlphaLane].div = 17'd510;
    end
    lanes_d[cac_pkg::AlphaLane].quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_o <= lanes_d;
      side_o  <= side1_q;
    end
  end

endmodule
`default_nettype wire

[rtl/cac_div_pipe.sv]
`default_nettype none
module cac_div_pipe (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire cac_pkg::lanes_t    lanes_i,
  input  wire cac_pkg::side_t     side_i,
  output logic                    valid_o,
  output cac_pkg::lanes_t         lanes_o,
  output cac_pkg::side_t          side_o
);

  logic            v_q    [cac_pkg::QSteps+1];
  cac_pkg::lanes_t lane_q [cac_pkg::QSteps+1];
  cac_pkg::side_t  side_q [cac_pkg::QSteps+1];

  always_comb begin
    v_q[0]    = valid_i;
    lane_q[0] = lanes_i;
    side_q[0] = side_i;
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < cac_pkg::QSteps; s++) begin : g_step
    localparam int unsigned Sh = cac_pkg::QSteps - 1 - s;
    cac_pkg::lanes_t nxt_d;

    always_comb begin
      logic [cac_pkg::RemW-1:0] trial;
      for (int l = 0; l < cac_pkg::Lanes; l++) begin
        trial = {{(cac_pkg::RemW-cac_pkg::DivW){1'b0}}, lane_q[s][l].div} << Sh;
        nxt_d[l].div = lane_q[s][l].div;
        if (lane_q[s][l].rem >= trial) begin
          nxt_d[l].rem = lane_q[s][l].rem - trial;
          nxt_d[l].quo = {lane_q[s][l].quo[cac_pkg::ChanW-2:0], 1'b1};
        end else begin
          nxt_d[l].rem = lane_q[s][l].rem;
          nxt_d[l].quo = {lane_q[s][l].quo[cac_pkg::ChanW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lane_q[s+1] <= nxt_d;
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = v_q[cac_pkg::QSteps];
  assign lanes_o = lane_q[cac_pkg::QSteps];
  assign side_o  = side_q[cac_pkg::QSteps];

endmodule
`default_nettype wire

[rtl/coverage_alpha_compositor.sv]
// Throughput: one pixel per clock while the output is not stalled; two
// front stages of 8-bit products and sums feed eight restoring-division
// stages, one quotient bit each.
// A stall on the output freezes every stage at once; ready is combinational.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the canvas
// to 800 x 480.
`default_nettype none
module coverage_alpha_compositor (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  cac_pix_in_if.sink    pix_in_i,
  cac_pix_out_if.source pix_out_o,
  cac_cfg_if.sink       cfg_i
);

  // Canvas registers; writes are taken at any time.
  logic [cac_pkg::CanvasW-1:0] width_q;
  logic [cac_pkg::CanvasW-1:0] height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cac_pkg::WidthReset;
      height_q <= cac_pkg::HeightReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        cac_pkg::RegCanvasWidth:  width_q  <= cfg_i.data;
        cac_pkg::RegCanvasHeight: height_q <= cfg_i.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Advance the whole pipeline unless the output holds a beat not yet taken.
  logic en;
  logic out_valid;
  assign en             = !out_valid || pix_out_o.ready;
  assign pix_in_i.ready = en;

  cac_pkg::pix_t pix;
  always_comb begin
    pix.pixel_x    = pix_in_i.pixel_x;
    pix.pixel_y    = pix_in_i.pixel_y;
    pix.src_red    = pix_in_i.src_red;
    pix.src_green  = pix_in_i.src_green;
    pix.src_blue   = pix_in_i.src_blue;
    pix.write_mode = pix_in_i.write_mode;
    pix.coverage   = pix_in_i.coverage;
    pix.dst_red    = pix_in_i.dst_red;
    pix.dst_green  = pix_in_i.dst_green;
    pix.dst_blue   = pix_in_i.dst_blue;
    pix.dst_alpha  = pix_in_i.dst_alpha;
  end

  logic            front_valid;
  cac_pkg::lanes_t front_lanes;
  cac_pkg::side_t  front_side;

  cac_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (pix_in_i.valid),
    .pix_i    (pix),
    .width_i  (width_q),
    .height_i (height_q),
    .valid_o  (front_valid),
    .lanes_o  (front_lanes),
    .side_o   (front_side)
  );

  // The last division stage is the output register.
  cac_pkg::lanes_t div_lanes;
  cac_pkg::side_t  div_side;

  cac_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .lanes_i (front_lanes),
    .side_i  (front_side),
    .valid_o (out_valid),
    .lanes_o (div_lanes),
    .side_o  (div_side)
  );

  // Skipped pixels and erase keep the destination colour.
  logic keep_rgb;
  assign keep_rgb               = div_side.off || div_side.erase;
  assign pix_out_o.valid        = out_valid;
  assign pix_out_o.write_enable = !div_side.off;
  assign pix_out_o.out_red      = keep_rgb ? div_side.dst_red   : div_lanes[0].quo;
  assign pix_out_o.out_green    = keep_rgb ? div_side.dst_green : div_lanes[1].quo;
  assign pix_out_o.out_blue     = keep_rgb ? div_side.dst_blue  : div_lanes[2].quo;
  assign pix_out_o.out_alpha    = div_side.off ? div_side.dst_alpha
                                               : div_lanes[cac_pkg::AlphaLane].quo;

endmodule
`default_nettype wire

[rtl/cac_checker.sv]
`default_nettype none
`include "coverage_alpha_compositor_defines.svh"
module cac_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_alpha_i,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_i
);

  `CAC_ASSERT_HOLD(a_out_hold, out_valid_i && !out_ready_i, out_alpha_i, "stalled beat changed")
  `CAC_ASSERT(a_ready_rule, in_ready_i == (!out_valid_i || out_ready_i), "input ready mismatch")
  `CAC_ASSERT(a_valid_hold, (out_valid_i && !out_ready_i) |=> out_valid_i, "stalled beat dropped")
  `CAC_ASSERT(a_cfg_ready, cfg_valid_i |-> cfg_ready_i, "config write refused")

endmodule

bind coverage_alpha_compositor cac_checker u_cac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_in_i.valid),
  .in_ready_i  (pix_in_i.ready),
  .out_valid_i (pix_out_o.valid),
  .out_ready_i (pix_out_o.ready),
  .out_alpha_i (pix_out_o.out_alpha),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);
`default_nettype wire

[dv/cac_chk.sv]
`timescale 1ns / 100ps
`default_nettype none
module cac_chk (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  cac_pix_in_if.sink      pix_in_i,
  cac_pix_out_if.sink     pix_out_i,
  cac_cfg_if.sink         cfg_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o
);

  typedef struct packed {
    logic       we;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } px_res_t;

  logic [cac_pkg::CanvasW-1:0] width_q;
  logic [cac_pkg::CanvasW-1:0] height_q;
  px_res_t                     px_exp_q[$];

  function automatic logic [7:0] div_half_up(longint unsigned num, longint unsigned den);
    longint unsigned v;
    v = (2 * num + den) / (2 * den);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic px_res_t blend_pixel(cac_pkg::pix_t p);
    px_res_t         r;
    longint unsigned c, da, inv, den;
    logic [7:0]      s[3];
    logic [7:0]      d[3];
    logic [7:0]      o[3];
    r = '{1'b1, p.dst_red, p.dst_green, p.dst_blue, p.dst_alpha};
    if (p.pixel_x[15] || p.pixel_y[15] || p.pixel_x >= width_q ||
        p.pixel_y >= height_q || p.coverage == 0) begin
      r.we = 1'b0;
      return r;
    end
    c   = p.coverage;
    da  = p.dst_alpha;
    inv = 255 - c;
    if (p.write_mode == cac_pkg::ModeErase) begin
      r.alpha = 8'((da * inv) / 255);
      return r;
    end
    d = '{p.dst_red, p.dst_green, p.dst_blue};
    s = '{p.src_red, p.src_green, p.src_blue};
    if (p.write_mode == cac_pkg::ModeComplement) begin
      foreach (s[k]) s[k] = 8'd255 - d[k];
    end
    den = c * 255 + da * inv;
    foreach (o[k]) o[k] = div_half_up(s[k] * c * 255 + d[k] * da * inv, den);
    r.red   = o[0];
    r.green = o[1];
    r.blue  = o[2];
    r.alpha = div_half_up(den, 255);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cac_pkg::pix_t p;
    px_res_t       e;
    int unsigned   errs;
    errs = 0;
    if (!rst_ni) begin
      width_q      <= cac_pkg::WidthReset;
      height_q     <= cac_pkg::HeightReset;
      fail_count_o <= 0;
      pending_o    <= 0;
      px_exp_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == cac_pkg::RegCanvasWidth) width_q <= cfg_i.data;
        else if (cfg_i.index == cac_pkg::RegCanvasHeight) height_q <= cfg_i.data;
      end
      if (pix_out_i.valid && pix_out_i.ready) begin
        if (px_exp_q.size() == 0) begin
          $error("unexpected pixel result");
          errs++;
        end else begin
          e = px_exp_q.pop_front();
          if (e.we !== pix_out_i.write_enable) begin
            $error("write_enable exp %0d got %0d", e.we, pix_out_i.write_enable);
            errs++;
          end
          if (e.red !== pix_out_i.out_red) begin
            $error("out_red exp %0d got %0d", e.red, pix_out_i.out_red);
            errs++;
          end
          if (e.green !== pix_out_i.out_green) begin
            $error("out_green exp %0d got %0d", e.green, pix_out_i.out_green);
            errs++;
          end
          if (e.blue !== pix_out_i.out_blue) begin
            $error("out_blue exp %0d got %0d", e.blue, pix_out_i.out_blue);
            errs++;
          end
          if (e.alpha !== pix_out_i.out_alpha) begin
            $error("out_alpha exp %0d got %0d", e.alpha, pix_out_i.out_alpha);
            errs++;
          end
        end
      end
      // config writes only happen while idle, so current width/height apply
      if (pix_in_i.valid && pix_in_i.ready) begin
        p = '{pix_in_i.pixel_x, pix_in_i.pixel_y, pix_in_i.src_red, pix_in_i.src_green,
              pix_in_i.src_blue, pix_in_i.write_mode, pix_in_i.coverage, pix_in_i.dst_red,
              pix_in_i.dst_green, pix_in_i.dst_blue, pix_in_i.dst_alpha};
        px_exp_q.insert(px_exp_q.size(), blend_pixel(p));
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= $unsigned(px_exp_q.size());
    end
  end

endmodule
`default_nettype wire

[dv/tb_coverage_alpha_compositor.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_coverage_alpha_compositor;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  bit          calm_in;      // suppress random sender gaps
  bit          calm_out;     // suppress random receiver stalls
  bit          hold_out;     // long receiver hold-off
  int unsigned hold_len;

  cac_pix_in_if  pix_in ();
  cac_pix_out_if pix_out ();
  cac_cfg_if     cfg ();

  coverage_alpha_compositor uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_in_i (pix_in.sink),
    .pix_out_o(pix_out.source),
    .cfg_i    (cfg.sink)
  );

  cac_chk u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_in_i    (pix_in.sink),
    .pix_out_i   (pix_out.sink),
    .cfg_i       (cfg.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // Give up after a generous bound on the run of 494 beats.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stalls, except during calm stretches; hold off on request.
  initial begin
    pix_out.ready = 1'b0;
    hold_len = 0;
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        pix_out.ready <= 1'b0;
        hold_len++;
      end else begin
        pix_out.ready <= calm_out ? 1'b1 : ($urandom_range(99) >= 30);
      end
    end
  end

  // Drive one pixel beat; random gaps may come before it unless calm_in is set. Valid stays up afterwards.
  task automatic send_pixel(cac_pkg::pix_t p);
    while (!calm_in && $urandom_range(99) < 30) begin
      pix_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_in.valid      <= 1'b1;
    pix_in.pixel_x    <= p.pixel_x;
    pix_in.pixel_y    <= p.pixel_y;
    pix_in.src_red    <= p.src_red;
    pix_in.src_green  <= p.src_green;
    pix_in.src_blue   <= p.src_blue;
    pix_in.write_mode <= p.write_mode;
    pix_in.coverage   <= p.coverage;
    pix_in.dst_red    <= p.dst_red;
    pix_in.dst_green  <= p.dst_green;
    pix_in.dst_blue   <= p.dst_blue;
    pix_in.dst_alpha  <= p.dst_alpha;
    do @(posedge clk_i); while (!pix_in.ready);
    @(negedge clk_i);
  endtask

  // Drop valid, drain every outstanding result, then allow the pipeline to settle.
  task automatic drain_results();
    pix_in.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [cac_pkg::CanvasW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random pixel; coordinates mostly fall on the canvas, some just past it or anywhere in 16 bits.
  function automatic cac_pkg::pix_t rand_pixel(logic [cac_pkg::CanvasW-1:0] w,
                                               logic [cac_pkg::CanvasW-1:0] h);
    cac_pkg::pix_t p;
    logic [127:0]  bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    p = bits[$bits(cac_pkg::pix_t)-1:0];
    case ($urandom_range(3))
      0: ;  // full 16-bit range, negatives included
      1: begin
        p.pixel_x = 16'($urandom_range(32'(w) + 32'd2));
        p.pixel_y = 16'($urandom_range(32'(h) + 32'd2));
      end
      default: begin
        p.pixel_x = (w > 0) ? 16'($urandom_range(32'(w) - 32'd1)) : 16'd0;
        p.pixel_y = (h > 0) ? 16'($urandom_range(32'(h) - 32'd1)) : 16'd0;
      end
    endcase
    case ($urandom_range(7))
      0: p.coverage = 8'd0;
      1: p.coverage = 8'd255;
      default: ;
    endcase
    case ($urandom_range(7))
      0: p.dst_alpha = 8'd0;
      1: p.dst_alpha = 8'd255;
      default: ;
    endcase
    return p;
  endfunction

  task automatic random_phase(logic [cac_pkg::CanvasW-1:0] w, logic [cac_pkg::CanvasW-1:0] h,
                              int n);
    repeat (n) send_pixel(rand_pixel(w, h));
  endtask

  initial begin
    cac_pkg::pix_t p;
    logic [cac_pkg::CanvasW-1:0] w, h;
    pix_in.valid = 1'b0;
    pix_in.pixel_x = '0;
    pix_in.pixel_y = '0;
    pix_in.src_red = '0;
    pix_in.src_green = '0;
    pix_in.src_blue = '0;
    pix_in.write_mode = cac_pkg::ModeReplace;
    pix_in.coverage = '0;
    pix_in.dst_red = '0;
    pix_in.dst_green = '0;
    pix_in.dst_blue = '0;
    pix_in.dst_alpha = '0;
    cfg.valid = 1'b0;
    cfg.index = cac_pkg::RegCanvasWidth;
    cfg.data = '0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    hold_out = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed beats on the reset canvas of 800 x 480.
    p = '{16'd0, 16'd0, 8'd255, 8'd0, 8'd128, cac_pkg::ModeReplace, 8'd255,
          8'd10, 8'd20, 8'd30, 8'd0};
    send_pixel(p);
    p.write_mode = cac_pkg::ModeOverlay; p.coverage = 8'd1; p.dst_alpha = 8'd255;
    send_pixel(p);
    p.write_mode = cac_pkg::ModeErase; p.coverage = 8'd100; p.dst_alpha = 8'd200;
    send_pixel(p);
    p.write_mode = cac_pkg::ModeErase; p.coverage = 8'd255;
    send_pixel(p);
    p.write_mode = cac_pkg::ModeComplement; p.coverage = 8'd128; p.dst_alpha = 8'd77;
    send_pixel(p);
    p.coverage = 8'd0;                                  // zero coverage skips
    send_pixel(p);
    p.coverage = 8'd200; p.write_mode = cac_pkg::ModeReplace;
    p.pixel_x = 16'hFFFF;                               // negative x
    send_pixel(p);
    p.pixel_x = 16'h8000; p.pixel_y = 16'h7FFF;
    send_pixel(p);
    p.pixel_x = 16'd799; p.pixel_y = 16'd479;           // last pixel on canvas
    send_pixel(p);
    p.pixel_x = 16'd800;                                // just off the right edge
    send_pixel(p);
    p.pixel_x = 16'd5; p.pixel_y = 16'd480;             // just off the bottom
    send_pixel(p);
    p.pixel_y = 16'hFFFF;                               // negative y
    send_pixel(p);
    p = '{16'd3, 16'd3, 8'd255, 8'd255, 8'd255, cac_pkg::ModeOverlay, 8'd255,
          8'd255, 8'd255, 8'd255, 8'd255};
    send_pixel(p);
    p.src_red = 8'd0; p.src_green = 8'd0; p.src_blue = 8'd0; p.coverage = 8'd127;
    send_pixel(p);
    drain_results();

    // Extreme canvas sizes and two random ones, each followed by random traffic.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin w = 13'd1; h = 13'd1; end
        1: begin w = 13'd4096; h = 13'd4096; end
        2: begin w = 13'd0; h = 13'd100; end
        3: begin w = 13'h1FFF; h = 13'h1FFF; end
        default: begin
          w = 13'($urandom_range(1, 4096));
          h = 13'($urandom_range(1, 4096));
        end
      endcase
      write_reg(cac_pkg::RegCanvasWidth, w);
      write_reg(cac_pkg::RegCanvasHeight, h);
      calm_in = (ph == 1);
      calm_out = (ph == 1);
      if (ph == 4) begin
        // Hold the receiver off while beats keep coming, so the pipe backs up.
        fork
          random_phase(w, h, 80);
          begin
            hold_out = 1'b1;
            wait (hold_len >= 60);
            hold_out = 1'b0;
          end
        join
      end else begin
        random_phase(w, h, 80);
      end
      // Pause the sender until every result is back.
      drain_results();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
